@@ rtl/gdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types, codes and calendar helpers for the Gregorian date counter.
// ----------------------------------------------------------------------------
package gdc_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned QUOT_W   = 8;   // year / 100 for any 14-bit year
  localparam int unsigned REM_W    = 7;   // year % 100
  localparam int unsigned SUM_W    = 10;  // Gauss weekday sum before mod 7
  localparam int unsigned PROD_W   = YEAR_W + 13;
  localparam int unsigned MPROD_W  = SUM_W + 14;

  // Reciprocal of 100: exact quotient for every 14-bit value
  localparam logic [PROD_W-1:0]  DIV100_RECIP = PROD_W'(5243);
  localparam int unsigned        DIV100_SHIFT = 19;
  // Reciprocal of 7: exact quotient for every 10-bit value
  localparam logic [MPROD_W-1:0] DIV7_RECIP   = MPROD_W'(2341);
  localparam int unsigned        DIV7_SHIFT   = 14;

  // Item modes
  localparam logic MODE_SET     = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Months
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0]  DAY_FIRST  = 5'd1;
  localparam logic [YEAR_W-1:0] YEAR_FIRST = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
  localparam logic [YEAR_W-1:0] YEAR_RESET = 14'd2000;

  localparam logic [LEN_W-1:0] LEN_28 = 5'd28;
  localparam logic [LEN_W-1:0] LEN_29 = 5'd29;
  localparam logic [LEN_W-1:0] LEN_30 = 5'd30;
  localparam logic [LEN_W-1:0] LEN_31 = 5'd31;
  localparam logic [LEN_W-1:0] LEN_NONE = 5'd0;

  localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  // Stage payload handed from the date register stage to the weekday stages
  typedef struct packed {
    date_t              date;
    logic               set_error;
    logic [DAY_W-1:0]   query_day;
  } gdc_item_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic [REM_W-1:0]  rem;
  } div100_t;

  // Split a year into century and year of century
  function automatic div100_t div100(input logic [YEAR_W-1:0] y);
    logic [PROD_W-1:0] prod;
    logic [YEAR_W-1:0] back;
    div100_t           res;
    prod     = PROD_W'(y) * DIV100_RECIP;
    res.quot = prod[DIV100_SHIFT +: QUOT_W];
    back     = YEAR_W'(res.quot) * YEAR_W'(100);
    res.rem  = REM_W'(y - back);
    return res;
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    div100_t d;
    d = div100(y);
    return ((y[1:0] == 2'b00) && (d.rem != '0)) ||
           ((d.rem == '0) && (d.quot[1:0] == 2'b00));
  endfunction

  // Month length; zero for a month code that is not a month
  function automatic logic [LEN_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic               leap);
    logic [LEN_W-1:0] n;
    unique case (m)
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC: n = LEN_31;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = LEN_30;
      MONTH_FEB: n = leap ? LEN_29 : LEN_28;
      default:   n = LEN_NONE;
    endcase
    return n;
  endfunction

  // floor(2.6*m - 0.2) mod 7, with March as Gauss month 1
  function automatic logic [WDAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [WDAY_W-1:0] o;
    unique case (m)
      MONTH_JAN: o = 3'd0;
      MONTH_FEB: o = 3'd3;
      MONTH_MAR: o = 3'd2;
      MONTH_APR: o = 3'd5;
      MONTH_MAY: o = 3'd0;
      MONTH_JUN: o = 3'd3;
      MONTH_JUL: o = 3'd5;
      MONTH_AUG: o = 3'd1;
      MONTH_SEP: o = 3'd4;
      MONTH_OCT: o = 3'd6;
      MONTH_NOV: o = 3'd2;
      MONTH_DEC: o = 3'd4;
      default:   o = 3'd0;
    endcase
    return o;
  endfunction

  function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] a);
    logic [MPROD_W-1:0] prod;
    logic [SUM_W-1:0]   q;
    prod = MPROD_W'(a) * DIV7_RECIP;
    q    = prod[DIV7_SHIFT +: SUM_W];
    return WDAY_W'(a - SUM_W'(q * SUM_W'(7)));
  endfunction

endpackage

@@ rtl/gdc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_in_if
// Input channel: one set or advance transaction with its query day.
// ----------------------------------------------------------------------------
interface gdc_in_if import gdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [DAY_W-1:0]   new_day;
  logic [MONTH_W-1:0] new_month;
  logic [YEAR_W-1:0]  new_year;
  logic [DAY_W-1:0]   query_day;

  modport source (output valid, mode, new_day, new_month, new_year, query_day,
                  input ready);
  modport sink   (input valid, mode, new_day, new_month, new_year, query_day,
                  output ready);
endinterface

@@ rtl/gdc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_out_if
// Result channel: stored date, month length, weekday and error flag.
// ----------------------------------------------------------------------------
interface gdc_out_if import gdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   cur_day;
  logic [MONTH_W-1:0] cur_month;
  logic [YEAR_W-1:0]  cur_year;
  logic [LEN_W-1:0]   month_length;
  logic [WDAY_W-1:0]  weekday;
  logic               set_error;

  modport source (output valid, cur_day, cur_month, cur_year, month_length,
                  weekday, set_error, input ready);
  modport sink   (input valid, cur_day, cur_month, cur_year, month_length,
                  weekday, set_error, output ready);
endinterface

@@ rtl/gdc_weekday_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdc_weekday_pipe
// Two-stage result path: month length and century split, then the Gauss
// weekday sum reduced mod 7 into the output register.
// ----------------------------------------------------------------------------
module gdc_weekday_pipe import gdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  gdc_item_t        item,
  gdc_out_if.source        out_ch
);

  logic              vc_r;
  logic              rdy_c;
  logic              rdy_d;
  gdc_item_t         itc_r;
  logic [LEN_W-1:0]  len_r;
  logic [REM_W-1:0]  yoc_r;
  logic [REM_W-1:0]  cent_r;
  logic [WDAY_W-1:0] moff_r;

  logic              leap_c;
  logic [YEAR_W-1:0] full_c;
  div100_t           split_c;
  logic [SUM_W-1:0]  sum_d;

  logic               out_valid_r;
  logic [DAY_W-1:0]   out_day_r;
  logic [MONTH_W-1:0] out_month_r;
  logic [YEAR_W-1:0]  out_year_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [WDAY_W-1:0]  out_wday_r;
  logic               out_err_r;

  // Stage ready chain
  assign rdy_d      = !out_valid_r || out_ch.ready;
  assign rdy_c      = !vc_r || rdy_d;
  assign item_ready = rdy_c;

  // Month length and Gauss year split; Jan and Feb count in the year before
  assign leap_c  = is_leap(item.date.year);
  assign full_c  = (item.date.month <= MONTH_FEB) ? item.date.year - YEAR_FIRST
                                                  : item.date.year;
  assign split_c = div100(full_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (rdy_c) begin
      vc_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && item_valid) begin
      itc_r  <= item;
      len_r  <= days_in(item.date.month, leap_c);
      yoc_r  <= split_c.rem;
      cent_r <= REM_W'(split_c.quot);
      moff_r <= month_offset(item.date.month);
    end
  end

  // Weekday sum; -2c is taken as +5c mod 7
  assign sum_d = SUM_W'(itc_r.query_day) + SUM_W'(moff_r) + SUM_W'(yoc_r)
               + SUM_W'(yoc_r >> 2) + SUM_W'(cent_r >> 2)
               + SUM_W'(cent_r) * SUM_W'(5);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_d) begin
      out_valid_r <= vc_r;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rdy_d && vc_r) begin
      out_day_r   <= itc_r.date.day;
      out_month_r <= itc_r.date.month;
      out_year_r  <= itc_r.date.year;
      out_len_r   <= len_r;
      out_wday_r  <= mod7(sum_d);
      out_err_r   <= itc_r.set_error;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cur_day      = out_day_r;
  assign out_ch.cur_month    = out_month_r;
  assign out_ch.cur_year     = out_year_r;
  assign out_ch.month_length = out_len_r;
  assign out_ch.weekday      = out_wday_r;
  assign out_ch.set_error    = out_err_r;

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_len_r >= LEN_28) && (out_len_r <= LEN_31))
    else $error("month length out of range");

  a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_wday_r <= WDAY_SAT))
    else $error("weekday out of range");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vc_r && !rdy_d) |=> vc_r && $stable(itc_r))
    else $error("middle stage lost a stalled transaction");
`endif

endmodule

@@ rtl/gregorian_date_counter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_counter_core
// Gregorian date register with checked load, one-day advance and Gauss
// weekday lookup for a day of the current month.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction: mode 0 loads new_day/new_month/new_year
//   after a month, year, day and leap-year check (a refused load keeps the
//   date and flags set_error); mode 1 advances the date one day, wrapping
//   31 Dec 9999 to 1 Jan 0001. query_day picks the day whose weekday is
//   reported. out_ch returns one result per transaction, in order.
//   Pipeline: input register, date register, split stage, output register.
//   Throughput: one transaction per cycle while out_ch.ready is high; each
//   taken transaction updates the date register, so back-to-back advances
//   see each other.
//   Reset: the date becomes 1 Jan 2000 and all stages are emptied.
//   Stall: when out_ch.ready is low the four stages fill and then
//   in_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gregorian_date_counter_core import gdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gdc_in_if.sink    in_ch,
  gdc_out_if.source out_ch
);

  // Input register
  logic               va_r;
  logic               mode_r;
  logic [DAY_W-1:0]   new_day_r;
  logic [MONTH_W-1:0] new_month_r;
  logic [YEAR_W-1:0]  new_year_r;
  logic [DAY_W-1:0]   query_day_r;

  // Date register stage
  logic               vb_r;
  date_t              stored_r;
  date_t              stored_nxt;
  gdc_item_t          item_r;
  logic               set_err_nxt;
  logic               rdy_a;
  logic               rdy_b;
  logic               take_b;
  logic               item_ready;

  logic               cur_leap;
  logic [LEN_W-1:0]   cur_len;
  logic               new_leap;
  logic               set_ok;

  assign rdy_b       = !vb_r || item_ready;
  assign rdy_a       = !va_r || rdy_b;
  assign take_b      = va_r && rdy_b;
  assign in_ch.ready = rdy_a;

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_ch.valid) begin
      mode_r      <= in_ch.mode;
      new_day_r   <= in_ch.new_day;
      new_month_r <= in_ch.new_month;
      new_year_r  <= in_ch.new_year;
      query_day_r <= in_ch.query_day;
    end
  end

  // Check a load and step the date
  assign cur_leap = is_leap(stored_r.year);
  assign cur_len  = days_in(stored_r.month, cur_leap);
  assign new_leap = is_leap(new_year_r);
  assign set_ok   = (new_month_r >= MONTH_JAN) && (new_month_r <= MONTH_DEC) &&
                    (new_year_r >= YEAR_FIRST) && (new_year_r <= YEAR_MAX) &&
                    (new_day_r >= DAY_FIRST) &&
                    (LEN_W'(new_day_r) <= days_in(new_month_r, new_leap));

  always_comb begin
    stored_nxt  = stored_r;
    set_err_nxt = 1'b0;
    if (mode_r == MODE_ADVANCE) begin
      if (LEN_W'(stored_r.day) >= cur_len) begin
        stored_nxt.day = DAY_FIRST;
        if (stored_r.month == MONTH_DEC) begin
          stored_nxt.month = MONTH_JAN;
          stored_nxt.year  = (stored_r.year >= YEAR_MAX) ? YEAR_FIRST
                                                         : stored_r.year + YEAR_FIRST;
        end else begin
          stored_nxt.month = stored_r.month + MONTH_JAN;
        end
      end else begin
        stored_nxt.day = stored_r.day + DAY_FIRST;
      end
    end else if (set_ok) begin
      stored_nxt.day   = new_day_r;
      stored_nxt.month = new_month_r;
      stored_nxt.year  = new_year_r;
    end else begin
      set_err_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r           <= 1'b0;
      stored_r.day   <= DAY_FIRST;
      stored_r.month <= MONTH_JAN;
      stored_r.year  <= YEAR_RESET;
    end else begin
      if (rdy_b) begin
        vb_r <= va_r;
      end
      if (take_b) begin
        stored_r <= stored_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_b) begin
      item_r.date      <= stored_nxt;
      item_r.set_error <= set_err_nxt;
      item_r.query_day <= query_day_r;
    end
  end

  gdc_weekday_pipe u_weekday (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (vb_r),
    .item_ready (item_ready),
    .item       (item_r),
    .out_ch     (out_ch)
  );

`ifndef SYNTHESIS
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (stored_r.month >= MONTH_JAN) && (stored_r.month <= MONTH_DEC) &&
    (stored_r.day >= DAY_FIRST) && (stored_r.year >= YEAR_FIRST) &&
    (stored_r.year <= YEAR_MAX))
    else $error("stored date out of range");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !take_b |=> $stable(stored_r))
    else $error("date changed without a transaction");

  a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (take_b && set_err_nxt) |=> $stable(stored_r))
    else $error("refused load changed the date");

  a_advance_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take_b && (mode_r == MODE_ADVANCE)) |=>
      (stored_r.day == $past(stored_r.day) + DAY_FIRST) || (stored_r.day == DAY_FIRST))
    else $error("advance did not step one day");
`endif

endmodule
